FILE: src/svpc_pkg.sv
// shared types, widths and constants for the svpwm min-max compare block
`timescale 1ns / 1ps
`default_nettype none

package svpc_pkg;

    // field widths
    localparam int unsigned VOLT_W  = 16;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned DC_W    = 16;

    // phase voltages in Q.23, sum of max and min, and the Q.24 offset-corrected phase
    localparam int unsigned P_W   = VOLT_W + 17;
    localparam int unsigned S_W   = P_W + 1;
    localparam int unsigned P2_W  = P_W + 2;

    // full bus span in Q.24 is dc * 2^16, half span dc * 2^15
    localparam int unsigned SPAN_SHIFT = 16;
    localparam int unsigned X_W        = DC_W + SPAN_SHIFT;
    localparam int unsigned NUM_W      = X_W + COUNT_W;

    // sqrt(3)/2 in Q1.15
    localparam logic signed [16:0] SQRT3_HALF_Q15 = 17'sd28378;

    // register reset values
    localparam logic [DC_W-1:0]    DC_BUS_RESET = DC_W'(6144);
    localparam logic [COUNT_W-1:0] PERIOD_RESET = COUNT_W'(5000);

    // register map, index is paddr[2]
    localparam int unsigned APB_ADDR_W = 3;
    localparam logic REG_DC_BUS = 1'b0;
    localparam logic REG_PERIOD = 1'b1;

    typedef logic signed [P2_W-1:0] t_p2;

    typedef struct packed {
        logic signed [VOLT_W-1:0] v_alpha;
        logic signed [VOLT_W-1:0] v_beta;
    } t_in_item;

    typedef struct packed {
        logic [COUNT_W-1:0] compare_a;
        logic [COUNT_W-1:0] compare_b;
        logic [COUNT_W-1:0] compare_c;
    } t_out_item;

endpackage

`default_nettype wire

FILE: src/svpwm_minmax_compare.sv
// top level: apb registers, phase pipeline, compare pipeline and output buffer
// Turns one alpha/beta voltage command into three centre-aligned PWM compare
// counts (inverse Clarke, min-max zero-sequence injection, scaling by
// pwm_period / dc_bus_voltage, clamp to 0..pwm_period). A new command is taken
// every cycle while the skid entry is free; a result passes five stages for the
// phase voltages, two for clamping and the period multiply, sixteen for the
// divider that produces one quotient bit per stage, and the output register. A
// skid entry behind the output register keeps input ready a registered signal,
// so a stalled result holds back input only once the skid entry fills.
// Registers: dc_bus_voltage at address 0 (a zero divides as 1), pwm_period at
// address 4; write them only while no command is in flight.
`timescale 1ns / 1ps
`default_nettype none

module svpwm_minmax_compare
    import svpc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire t_in_item              i_data,

    output logic                       o_valid,
    input  wire logic                  i_ready,
    output t_out_item                  o_data,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic [DC_W-1:0]    r_dc;
    logic [DC_W-1:0]    r_dc_eff;
    logic [COUNT_W-1:0] r_period;

    logic      adv;
    logic      ph_valid;
    t_p2       ph_p2 [3];
    logic      cmp_valid;
    t_out_item cmp_data;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc     <= DC_BUS_RESET;
            r_dc_eff <= DC_BUS_RESET;
            r_period <= PERIOD_RESET;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_DC_BUS: begin
                    r_dc     <= pwdata[DC_W-1:0];
                    r_dc_eff <= (pwdata[DC_W-1:0] == '0) ? DC_W'(1) : pwdata[DC_W-1:0];
                end
                REG_PERIOD: begin
                    r_period <= pwdata[COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_DC_BUS: prdata = 32'(r_dc);
            REG_PERIOD: prdata = 32'(r_period);
            default:    prdata = '0;
        endcase
    end

    assign o_ready = adv;

    svpc_phase u_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_valid (ph_valid),
        .o_p2    (ph_p2)
    );

    svpc_compare u_compare (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_valid  (ph_valid),
        .i_p2     (ph_p2),
        .i_dc     (r_dc_eff),
        .i_period (r_period),
        .o_valid  (cmp_valid),
        .o_data   (cmp_data)
    );

    svpc_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cmp_valid),
        .i_data  (cmp_data),
        .o_adv   (adv),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_ready (i_ready)
    );

endmodule

`default_nettype wire

FILE: src/svpc_phase.sv
// inverse clarke and min-max zero-sequence injection, five register stages
`timescale 1ns / 1ps
`default_nettype none

module svpc_phase
    import svpc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_adv,
    input  wire logic     i_valid,
    input  wire t_in_item i_data,
    output logic          o_valid,
    output t_p2           o_p2 [3]
);

    logic                r_v [5];

    logic signed [P_W-1:0] r1_a;
    logic signed [P_W-1:0] r1_nh;
    logic signed [P_W-1:0] r1_bk;
    logic signed [P_W-1:0] n1_a;
    logic signed [P_W-1:0] n1_nh;
    logic signed [P_W-1:0] n1_bk;

    logic signed [P_W-1:0] r2_ph [3];
    logic signed [P_W-1:0] r3_ph [3];
    logic signed [P_W-1:0] r3_hi;
    logic signed [P_W-1:0] r3_lo;
    logic signed [P_W-1:0] n3_hi;
    logic signed [P_W-1:0] n3_lo;
    logic signed [P_W-1:0] r4_ph [3];
    logic signed [S_W-1:0] r4_s;
    t_p2                   r5_p2 [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 5; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_adv) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < 5; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    // stage 1: scaled alpha terms and the beta product
    always_comb begin
        n1_a  = P_W'(i_data.v_alpha) <<< 15;
        n1_nh = -(P_W'(i_data.v_alpha) <<< 14);
        n1_bk = P_W'(i_data.v_beta) * P_W'(SQRT3_HALF_Q15);
    end

    // stage 3 compare network
    always_comb begin
        n3_hi = r2_ph[0];
        n3_lo = r2_ph[0];
        for (int k = 1; k < 3; k++) begin
            if (r2_ph[k] > n3_hi) begin
                n3_hi = r2_ph[k];
            end
            if (r2_ph[k] < n3_lo) begin
                n3_lo = r2_ph[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_a  <= n1_a;
            r1_nh <= n1_nh;
            r1_bk <= n1_bk;

            r2_ph[0] <= r1_a;
            r2_ph[1] <= r1_nh + r1_bk;
            r2_ph[2] <= r1_nh - r1_bk;

            r3_ph <= r2_ph;
            r3_hi <= n3_hi;
            r3_lo <= n3_lo;

            r4_ph <= r3_ph;
            r4_s  <= S_W'(r3_hi) + S_W'(r3_lo);

            // twice the phase minus (max + min)
            for (int k = 0; k < 3; k++) begin
                r5_p2[k] <= (P2_W'(r4_ph[k]) <<< 1) - P2_W'(r4_s);
            end
        end
    end

    assign o_valid = r_v[4];
    assign o_p2    = r5_p2;

endmodule

`default_nettype wire

FILE: src/svpc_compare.sv
// clamp, period scaling and a one-bit-per-stage divider for the three phases
`timescale 1ns / 1ps
`default_nettype none

module svpc_compare
    import svpc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_adv,
    input  wire logic               i_valid,
    input  wire t_p2                i_p2 [3],
    input  wire logic [DC_W-1:0]    i_dc,
    input  wire logic [COUNT_W-1:0] i_period,
    output logic                    o_valid,
    output t_out_item               o_data
);

    logic r_v [COUNT_W+2];

    // stage c1
    t_p2              n_half;
    t_p2              n_sum [3];
    logic [X_W-1:0]   n_x [3];
    logic             n_hi1 [3];
    logic             n_lo1 [3];
    logic [X_W-1:0]   r_x [3];
    logic             r_hi1 [3];
    logic             r_lo1 [3];

    // stage c2 and divider stages
    logic [NUM_W-1:0]   n_num [3];
    logic [NUM_W-1:0]   r_rem [3][COUNT_W+1];
    logic [COUNT_W-1:0] r_q   [3][COUNT_W+1];
    logic               r_hi  [3][COUNT_W+1];
    logic               r_lo  [3][COUNT_W+1];
    logic [NUM_W-1:0]   n_d   [COUNT_W];
    logic               n_ge  [3][COUNT_W];

    logic [COUNT_W-1:0] n_cmp [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < COUNT_W + 2; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_adv) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < COUNT_W + 2; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    // saturation tests against +/- half the bus span, offset into 0..span
    always_comb begin
        n_half = $signed({{(P2_W - DC_W - 15){1'b0}}, i_dc, 15'b0});
        for (int k = 0; k < 3; k++) begin
            n_hi1[k] = i_p2[k] >= n_half;
            n_lo1[k] = i_p2[k] <= -n_half;
            n_sum[k] = i_p2[k] + n_half;
            n_x[k]   = n_sum[k][X_W-1:0];
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_num[k] = r_x[k] * i_period;
        end
    end

    // restoring division by dc * 2^16, quotient msb first
    always_comb begin
        for (int j = 0; j < COUNT_W; j++) begin
            n_d[j] = NUM_W'(i_dc) << (SPAN_SHIFT + COUNT_W - 1 - j);
            for (int k = 0; k < 3; k++) begin
                n_ge[k][j] = r_rem[k][j] >= n_d[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int k = 0; k < 3; k++) begin
                r_x[k]      <= n_x[k];
                r_hi1[k]    <= n_hi1[k];
                r_lo1[k]    <= n_lo1[k];
                r_rem[k][0] <= n_num[k];
                r_q[k][0]   <= '0;
                r_hi[k][0]  <= r_hi1[k];
                r_lo[k][0]  <= r_lo1[k];
                for (int j = 0; j < COUNT_W; j++) begin
                    r_rem[k][j+1] <= n_ge[k][j] ? (r_rem[k][j] - n_d[j]) : r_rem[k][j];
                    r_q[k][j+1]   <= {r_q[k][j][COUNT_W-2:0], n_ge[k][j]};
                    r_hi[k][j+1]  <= r_hi[k][j];
                    r_lo[k][j+1]  <= r_lo[k][j];
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            priority if (r_hi[k][COUNT_W]) begin
                n_cmp[k] = i_period;
            end else if (r_lo[k][COUNT_W]) begin
                n_cmp[k] = '0;
            end else begin
                n_cmp[k] = r_q[k][COUNT_W];
            end
        end
    end

    assign o_valid          = r_v[COUNT_W+1];
    assign o_data.compare_a = n_cmp[0];
    assign o_data.compare_b = n_cmp[1];
    assign o_data.compare_c = n_cmp[2];

endmodule

`default_nettype wire

FILE: src/svpc_out_buf.sv
// output register with a skid entry, drives the pipeline advance
`timescale 1ns / 1ps
`default_nettype none

module svpc_out_buf
    import svpc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    input  wire t_out_item i_data,
    output logic           o_adv,
    output logic           o_valid,
    output t_out_item      o_data,
    input  wire logic      i_ready
);

    logic      r_hv;
    logic      r_sv;
    t_out_item r_hd;
    t_out_item r_sd;

    // pipeline moves only while the skid entry is free
    assign o_adv = !r_sv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (i_ready) begin
                r_sv <= 1'b0;
            end
        end else if (!r_hv || i_ready) begin
            r_hv <= i_valid;
        end else if (i_valid) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (i_ready) begin
                r_hd <= r_sd;
            end
        end else if (!r_hv || i_ready) begin
            r_hd <= i_data;
        end else begin
            r_sd <= i_data;
        end
    end

    assign o_valid = r_hv;
    assign o_data  = r_hd;

endmodule

`default_nettype wire

FILE: src/svpc_checker.sv
// port-level checks for the svpwm min-max compare block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module svpc_checker
    import svpc_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_ready,
    input wire logic                  o_valid,
    input wire logic                  i_ready,
    input wire t_out_item             o_data,
    input wire logic                  psel,
    input wire logic                  penable,
    input wire logic                  pwrite,
    input wire logic [APB_ADDR_W-1:0] paddr,
    input wire logic [31:0]           pwdata,
    input wire logic [31:0]           prdata,
    input wire logic                  pready
);

    // a stalled result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    // input is held off only while a result waits at the output
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled with empty output");

    // a stalled output with a full skid entry frees input once the result transfers
    a_ready_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready && i_ready |=> o_ready)
        else $error("input ready not restored after transfer");

    // a register reads back what was written to it
    a_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready) ##1 (!pwrite && paddr == $past(paddr))
        |-> prdata == 32'($past(pwdata[15:0])))
        else $error("register readback mismatch");

endmodule

bind svpwm_minmax_compare svpc_checker u_svpc_checker (.*);

`default_nettype wire

FILE: tb/testbench.sv
// self-checking testbench for the svpwm min-max compare block
`timescale 1ns / 1ps

module testbench;
    import svpc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 125;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    t_in_item              i_data  = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    t_out_item             o_data;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [31:0]           pwdata  = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // shadow copies of the block's registers
    logic [DC_W-1:0]    dc_bus_shadow = DC_BUS_RESET;
    logic [COUNT_W-1:0] period_shadow = PERIOD_RESET;

    t_out_item expected_compares[$];
    t_out_item oldest_compare;
    int        error_count   = 0;
    int        stall_cycles  = 0;
    logic      calm          = 1'b0;

    svpwm_minmax_compare DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // scale one Q.24 offset-corrected phase into a clamped compare count
    function automatic logic [COUNT_W-1:0] scale_to_count(longint p2, longint dc,
                                                          longint period);
        longint half_span;
        half_span = dc * 32768;
        if (p2 >= half_span) return COUNT_W'(period);
        if (p2 <= -half_span) return '0;
        return COUNT_W'(((p2 + half_span) * period) / (dc * 65536));
    endfunction

    function automatic t_out_item predict_compares(t_in_item cmd);
        longint    alpha, beta, pa, pb, pc, hi, lo, dc, period, k;
        t_out_item res;
        alpha  = longint'($signed(cmd.v_alpha));
        beta   = longint'($signed(cmd.v_beta));
        k      = longint'(SQRT3_HALF_Q15);
        dc     = (dc_bus_shadow == '0) ? 1 : longint'(dc_bus_shadow);
        period = longint'(period_shadow);
        // inverse clarke, phases in Q.23
        pa = alpha * 32768;
        pb = alpha * -16384 + beta * k;
        pc = alpha * -16384 - beta * k;
        hi = pa;
        if (pb > hi) hi = pb;
        if (pc > hi) hi = pc;
        lo = pa;
        if (pb < lo) lo = pb;
        if (pc < lo) lo = pc;
        // min-max injection: 2p - max - min is the shifted phase in Q.24
        res.compare_a = scale_to_count(2 * pa - hi - lo, dc, period);
        res.compare_b = scale_to_count(2 * pb - hi - lo, dc, period);
        res.compare_c = scale_to_count(2 * pc - hi - lo, dc, period);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [COUNT_W-1:0] want,
                               input logic [COUNT_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // every accepted command queues its expected compares
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready)
            expected_compares.push_back(predict_compares(i_data));
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_compares.size() == 0) begin
                $error("result transfer with no expected compares pending");
                error_count++;
            end else begin
                oldest_compare = expected_compares.pop_front();
                check_field("compare_a", oldest_compare.compare_a, o_data.compare_a);
                check_field("compare_b", oldest_compare.compare_b, o_data.compare_b);
                check_field("compare_c", oldest_compare.compare_c, o_data.compare_c);
            end
        end
    end

    always @(posedge i_clk) begin
        i_ready <= calm || ($urandom_range(99) >= 27);
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic send_cmd(input int alpha, input int beta);
        while (!calm && $urandom_range(99) < 27) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= '{v_alpha: VOLT_W'(alpha), v_beta: VOLT_W'(beta)};
        do @(posedge i_clk); while (!o_ready);
    endtask

    // one edge first so the last transfer is already queued
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_compares.size() != 0) @(posedge i_clk);
    endtask

    // write a register, then read it back
    task automatic write_register(input logic idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_DC_BUS) dc_bus_shadow = value;
        else period_shadow = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[15:0] !== value) begin
            $error("%s readback: expected %0d, got %0d",
                   (idx == REG_DC_BUS) ? "dc_bus_voltage" : "pwm_period",
                   value, prdata[15:0]);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [15:0] dc, input logic [15:0] period);
        wait_drained();
        write_register(REG_DC_BUS, dc);
        write_register(REG_PERIOD, period);
    endtask

    // reset values: 24 V bus, 5000 count period, commands around the linear range
    task automatic test_reset_values();
        send_cmd(0, 0);
        send_cmd(1, 0);
        send_cmd(-1, 0);
        send_cmd(0, 1);
        send_cmd(0, -1);
        send_cmd(3000, 0);
        send_cmd(-3000, 0);
        send_cmd(1500, 2598);
        send_cmd(32767, -32768);
        send_cmd(-32768, 32767);
    endtask

    task automatic test_bus_and_period_corners();
        // zero bus divides as one
        set_config(16'd0, 16'd5000);
        send_cmd(0, 0);
        send_cmd(1, 0);
        send_cmd(0, -1);
        // zero period forces every compare to zero
        set_config(16'd6144, 16'd0);
        send_cmd(1000, -700);
        send_cmd(32767, 32767);
        set_config(16'd65535, 16'd65535);
        send_cmd(32767, 0);
        send_cmd(-32768, 0);
        send_cmd(0, 32767);
        send_cmd(0, -32768);
        send_cmd(-32768, -32768);
        send_cmd(12345, -6789);
        set_config(16'd1, 16'd1);
        send_cmd(0, 0);
        send_cmd(1, 1);
        send_cmd(-1, 1);
    endtask

    task automatic test_random_commands();
        logic [15:0] dc, period;
        int          span;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase % 4)
                0: dc = 16'($urandom_range(1, 65535));
                1: dc = 16'($urandom_range(1, 255));
                2: dc = 16'd65535;
                default: dc = 16'($urandom_range(1024, 16384));
            endcase
            case (phase % 3)
                0: period = 16'($urandom_range(1, 65535));
                1: period = 16'd65535;
                default: period = 16'($urandom_range(1, 1000));
            endcase
            set_config(dc, period);
            calm = (phase == 5);
            // most commands stay near the bus range so the compares are not all clamped
            span = (int'(dc) > 32767) ? 32767 : int'(dc);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(99) < 80)
                    send_cmd(int'($urandom_range(2 * span)) - span,
                             int'($urandom_range(2 * span)) - span);
                else
                    send_cmd(int'($urandom_range(65535)), int'($urandom_range(65535)));
            end
            calm = 1'b0;
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_values();
        test_bus_and_period_corners();
        test_random_commands();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
